FILE: rtl/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

	localparam int KEY_W      = 256;
	localparam int VAL_W      = 64;
	localparam int SLOT_OUT_W = 13;

	// operation codes
	localparam logic [1:0] OP_FIND_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND        = 2'd1;
	localparam logic [1:0] OP_REMOVE      = 2'd2;
	localparam logic [1:0] OP_NONE        = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [63:0] new_value;
	} cht_req_t;

	typedef struct packed {
		logic                  found;
		logic [63:0]           result_value;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  lost;
		logic [63:0]           lost_value;
	} cht_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HA_GO,
		ST_HA_WAIT,
		ST_HB_GO,
		ST_HB_WAIT,
		ST_RD_A,
		ST_RD_B,
		ST_DECIDE,
		ST_EH1_GO,
		ST_EH1_WAIT,
		ST_EH2_GO,
		ST_EH2_WAIT,
		ST_EV_CHECK,
		ST_EV_RD,
		ST_EV_SWAP
	} cht_state_t;

endpackage

FILE: rtl/cht_slot_mod.sv
`timescale 1ns / 1ps

// 64-bit word mod TABLE_SIZE. Power of two: mask.
// Otherwise Horner over four 16-bit digits, each digit reduced with a
// Barrett step (multiply, multiply, subtract/correct).
module cht_slot_mod #(
	parameter int TABLE_SIZE = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [63:0]                   x,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] slot
);

	localparam int          SW      = $clog2(TABLE_SIZE);
	localparam bit          IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
	localparam logic [31:0] MU      = 32'(64'h1_0000_0000 / TABLE_SIZE);
	localparam logic [31:0] MOD     = 32'(TABLE_SIZE);

	logic        active_q;
	logic        done_q;
	logic [1:0]  phase_q;
	logic [1:0]  chunk_q;
	logic [63:0] x_q;
	logic [15:0] rem_q;
	logic [31:0] y_s1;
	logic [31:0] q_s1;
	logic [31:0] qm_s2;

	logic [31:0] y;
	logic [63:0] prod;
	logic [31:0] diff;
	logic [31:0] diff_c;

	assign y      = {rem_q, x_q[{chunk_q, 4'd0} +: 16]};
	assign prod   = 64'(y) * 64'(MU);
	assign diff   = y_s1 - qm_s2;
	assign diff_c = (diff >= MOD) ? (diff - MOD) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			phase_q  <= 2'd0;
			chunk_q  <= 2'd0;
		end else begin
			if (start) begin
				active_q <= !IS_POW2;
				done_q   <= IS_POW2;
				phase_q  <= 2'd0;
				chunk_q  <= 2'd3;
			end else begin
				// last phase of the last digit
				done_q <= active_q && (phase_q == 2'd2) && (chunk_q == 2'd0);
				if (active_q) begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						if (chunk_q == 2'd0) begin
							active_q <= 1'b0;
						end else begin
							chunk_q <= chunk_q - 2'd1;
						end
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= IS_POW2 ? 16'(x[SW-1:0]) : 16'd0;
		end else if (active_q) begin
			unique case (phase_q)
				2'd0: begin
					y_s1 <= y;
					q_s1 <= prod[63:32];
				end
				2'd1: qm_s2 <= q_s1 * MOD;
				default: rem_q <= diff_c[15:0];
			endcase
		end
	end

	assign done = done_q;
	assign slot = rem_q[SW-1:0];

endmodule

FILE: rtl/cuckoo_hash_table.sv
`timescale 1ns / 1ps

// Two-choice cuckoo table over a 256-bit key (four 64-bit words) and a 64-bit value,
// value zero meaning empty. Candidate slots are (word0^word1) and (word2^word3), both
// mod TABLE_SIZE. Command port: a beat is taken when start is high and busy is low;
// busy is low only when the block is idle. Every beat gives exactly one result beat:
// rsp is valid for the single cycle in which done is high and the receiver must take
// it then (no back-pressure). After reset the block sweeps the key and value memories
// to zero, one slot per cycle, so busy stays high until the sweep is through.
// Find, remove and insert without displacement hash both candidates in turn on the
// slot-hash unit, read both rows and then decide and give done; each displacement
// move hashes the evicted key, a second time when the evicted key left its first slot,
// then reads and rewrites the next slot, up to MAX_KICKS moves; the unused opcode
// gives done on the next cycle. busy drops the cycle after done. This order is set by
// the single read/write port pair of the two memories and the one shared hash unit,
// both walked by one sequencer.
module cuckoo_hash_table #(
	parameter int TABLE_SIZE = 8192,
	parameter int MAX_KICKS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cht_pkg::cht_req_t req,
	output logic              done,
	output cht_pkg::cht_rsp_t rsp
);

	localparam int SW = $clog2(TABLE_SIZE);
	localparam int KW = $clog2(MAX_KICKS + 1);

	// storage: key and value rows, one shared address on the write side
	logic [cht_pkg::KEY_W-1:0] key_mem [TABLE_SIZE];
	logic [cht_pkg::VAL_W-1:0] val_mem [TABLE_SIZE];
	logic [cht_pkg::KEY_W-1:0] key_rd_q;
	logic [cht_pkg::VAL_W-1:0] val_rd_q;

	logic                      key_we;
	logic                      val_we;
	logic [SW-1:0]             wr_addr;
	logic [cht_pkg::KEY_W-1:0] wr_key;
	logic [cht_pkg::VAL_W-1:0] wr_val;
	logic [SW-1:0]             rd_addr;

	// sequencer
	cht_pkg::cht_state_t state_q, state_d;
	logic [SW-1:0]       clr_q;
	logic [KW-1:0]       kicks_q;

	// item context
	cht_pkg::cht_req_t         req_q;
	cht_pkg::cht_rsp_t         rsp_q;
	cht_pkg::cht_rsp_t         dec_rsp;
	logic [SW-1:0]             h1_q;
	logic [SW-1:0]             h2_q;
	logic                      match_a_q;
	logic [cht_pkg::VAL_W-1:0] val_a_q;
	logic [cht_pkg::KEY_W-1:0] carry_key_q;
	logic [cht_pkg::VAL_W-1:0] carry_val_q;
	logic [SW-1:0]             cur_idx_q;
	logic [SW-1:0]             next_idx_q;

	// shared hash unit
	logic          hash_start;
	logic [63:0]   hash_x;
	logic          hash_done;
	logic [SW-1:0] hash_slot;

	// decode
	logic [cht_pkg::KEY_W-1:0] req_key;
	logic                      match_b;
	logic                      hit_a;
	logic                      hit;
	logic [SW-1:0]             hit_slot;
	logic [cht_pkg::VAL_W-1:0] hit_val;
	logic                      is_insert;
	logic                      evict;
	logic                      ev_stop;
	logic                      clr_last;

	cht_slot_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_slot_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.x     (hash_x),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	assign req_key   = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
	assign match_b   = (key_rd_q == req_key);   // h2 row is on the read port in ST_DECIDE
	assign hit_a     = match_a_q;
	assign hit       = match_a_q || match_b;
	assign hit_slot  = hit_a ? h1_q : h2_q;
	assign hit_val   = hit_a ? val_a_q : val_rd_q;
	assign is_insert = (req_q.operation == cht_pkg::OP_FIND_INSERT);
	// both candidates occupied by other keys: displace starting at h2
	assign evict     = is_insert && !hit && (val_a_q != '0) && (val_rd_q != '0);
	assign ev_stop   = (kicks_q == KW'(MAX_KICKS)) || (next_idx_q == h2_q);
	assign clr_last  = (clr_q == SW'(TABLE_SIZE - 1));

	// memories: registered read, one write per cycle
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cht_pkg::ST_CLEAR:    if (clr_last) state_d = cht_pkg::ST_IDLE;
			cht_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (req.operation == cht_pkg::OP_NONE) ? cht_pkg::ST_RD_A
						: cht_pkg::ST_HA_GO;
				end
			end
			cht_pkg::ST_HA_GO:    state_d = cht_pkg::ST_HA_WAIT;
			cht_pkg::ST_HA_WAIT:  if (hash_done) state_d = cht_pkg::ST_HB_GO;
			cht_pkg::ST_HB_GO:    state_d = cht_pkg::ST_HB_WAIT;
			cht_pkg::ST_HB_WAIT:  if (hash_done) state_d = cht_pkg::ST_RD_A;
			cht_pkg::ST_RD_A: begin
				// unused opcode lands here straight from idle and finishes at once
				state_d = (req_q.operation == cht_pkg::OP_NONE) ? cht_pkg::ST_IDLE
					: cht_pkg::ST_RD_B;
			end
			cht_pkg::ST_RD_B:     state_d = cht_pkg::ST_DECIDE;
			cht_pkg::ST_DECIDE:   state_d = evict ? cht_pkg::ST_EH1_GO : cht_pkg::ST_IDLE;
			cht_pkg::ST_EH1_GO:   state_d = cht_pkg::ST_EH1_WAIT;
			cht_pkg::ST_EH1_WAIT: begin
				if (hash_done) begin
					state_d = (hash_slot == cur_idx_q) ? cht_pkg::ST_EH2_GO
						: cht_pkg::ST_EV_CHECK;
				end
			end
			cht_pkg::ST_EH2_GO:   state_d = cht_pkg::ST_EH2_WAIT;
			cht_pkg::ST_EH2_WAIT: if (hash_done) state_d = cht_pkg::ST_EV_CHECK;
			cht_pkg::ST_EV_CHECK: state_d = ev_stop ? cht_pkg::ST_IDLE : cht_pkg::ST_EV_RD;
			cht_pkg::ST_EV_RD:    state_d = cht_pkg::ST_EV_SWAP;
			cht_pkg::ST_EV_SWAP: begin
				state_d = (val_rd_q != '0) ? cht_pkg::ST_EH1_GO : cht_pkg::ST_IDLE;
			end
			default:              state_d = cht_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, memory port, hash unit, result decision
	always_comb begin
		busy       = 1'b1;
		done       = 1'b0;
		rd_addr    = h1_q;
		hash_start = 1'b0;
		hash_x     = req_q.key_word0 ^ req_q.key_word1;
		key_we     = 1'b0;
		val_we     = 1'b0;
		wr_addr    = h1_q;
		wr_key     = '0;
		wr_val     = '0;
		dec_rsp    = '0;
		unique case (state_q)
			cht_pkg::ST_CLEAR: begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				wr_addr = clr_q;
			end
			cht_pkg::ST_IDLE:     busy = 1'b0;
			cht_pkg::ST_HA_GO:    hash_start = 1'b1;
			cht_pkg::ST_HB_GO: begin
				hash_start = 1'b1;
				hash_x     = req_q.key_word2 ^ req_q.key_word3;
			end
			cht_pkg::ST_RD_A: begin
				rd_addr = h1_q;
				done    = (req_q.operation == cht_pkg::OP_NONE);
			end
			cht_pkg::ST_RD_B:     rd_addr = h2_q;
			cht_pkg::ST_DECIDE: begin
				done = !evict;
				if (!is_insert) begin
					// find / remove
					if (hit) begin
						dec_rsp.found        = (hit_val != '0);
						dec_rsp.result_value = hit_val;
						dec_rsp.slot_index   = cht_pkg::SLOT_OUT_W'(hit_slot);
						if (req_q.operation == cht_pkg::OP_REMOVE) begin
							key_we  = 1'b1;
							val_we  = 1'b1;
							wr_addr = hit_slot;
						end
					end
				end else if (hit) begin
					dec_rsp.slot_index = cht_pkg::SLOT_OUT_W'(hit_slot);
					if (hit_val != '0) begin
						dec_rsp.found        = 1'b1;
						dec_rsp.result_value = hit_val;
					end else begin
						// key present with empty value: fill it
						dec_rsp.result_value = req_q.new_value;
						val_we               = 1'b1;
						wr_addr              = hit_slot;
						wr_val               = req_q.new_value;
					end
				end else begin
					// new key: h1 if free, else h2 (free or displaced)
					dec_rsp.result_value = req_q.new_value;
					key_we               = 1'b1;
					val_we               = 1'b1;
					wr_key               = req_key;
					wr_val               = req_q.new_value;
					wr_addr              = (val_a_q == '0) ? h1_q : h2_q;
					dec_rsp.slot_index   = cht_pkg::SLOT_OUT_W'(wr_addr);
				end
			end
			cht_pkg::ST_EH1_GO: begin
				hash_start = 1'b1;
				hash_x     = carry_key_q[63:0] ^ carry_key_q[127:64];
			end
			cht_pkg::ST_EH2_GO: begin
				hash_start = 1'b1;
				hash_x     = carry_key_q[191:128] ^ carry_key_q[255:192];
			end
			cht_pkg::ST_EV_CHECK: done = ev_stop;
			cht_pkg::ST_EV_RD:    rd_addr = next_idx_q;
			cht_pkg::ST_EV_SWAP: begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				wr_addr = next_idx_q;
				wr_key  = carry_key_q;
				wr_val  = carry_val_q;
				done    = (val_rd_q == '0);
			end
			default: ;
		endcase
	end

	// result beat: the decide and lost updates are combined on the strobe cycle
	always_comb begin
		rsp = rsp_q;
		if (state_q == cht_pkg::ST_DECIDE) begin
			rsp = dec_rsp;
		end else if (state_q == cht_pkg::ST_EV_CHECK) begin
			rsp.lost       = 1'b1;
			rsp.lost_value = carry_val_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_CLEAR;
			clr_q   <= '0;
			kicks_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cht_pkg::ST_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (state_q == cht_pkg::ST_DECIDE) begin
				kicks_q <= KW'(1);
			end else if (state_q == cht_pkg::ST_EV_SWAP && val_rd_q != '0) begin
				kicks_q <= kicks_q + KW'(1);
			end
		end
	end

	// item context
	always_ff @(posedge clk) begin
		unique case (state_q)
			cht_pkg::ST_IDLE: begin
				if (start) begin
					req_q <= req;
					rsp_q <= '0;
				end
			end
			cht_pkg::ST_HA_WAIT:  if (hash_done) h1_q <= hash_slot;
			cht_pkg::ST_HB_WAIT:  if (hash_done) h2_q <= hash_slot;
			cht_pkg::ST_RD_B: begin
				match_a_q <= (key_rd_q == req_key);
				val_a_q   <= val_rd_q;
			end
			cht_pkg::ST_DECIDE: begin
				rsp_q       <= dec_rsp;
				carry_key_q <= key_rd_q;
				carry_val_q <= val_rd_q;
				cur_idx_q   <= h2_q;
			end
			cht_pkg::ST_EH1_WAIT: if (hash_done) next_idx_q <= hash_slot;
			cht_pkg::ST_EH2_WAIT: if (hash_done) next_idx_q <= hash_slot;
			cht_pkg::ST_EV_SWAP: begin
				carry_key_q <= key_rd_q;
				carry_val_q <= val_rd_q;
				cur_idx_q   <= next_idx_q;
			end
			default: ;
		endcase
	end

	// a result beat is a single-cycle strobe
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

	// only insert can drop an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.lost) |-> (req_q.operation == cht_pkg::OP_FIND_INSERT))
		else $error("lost reported on a non-insert");

	// found always comes with the nonzero value that was found
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> (rsp.result_value != '0))
		else $error("found with empty value");

	// move count stays in range during displacement
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cht_pkg::ST_EV_CHECK) |-> (kicks_q != '0 && kicks_q <= KW'(MAX_KICKS)))
		else $error("displacement count out of range");

	// a displacement chain never rewrites the slot the new key went to
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cht_pkg::ST_EV_SWAP) |-> (next_idx_q != h2_q))
		else $error("displacement wrote back into h2");

	// hash unit is started only from its go/wait state pairs, never while one is running
	assert property (@(posedge clk) disable iff (!arst_n)
		hash_start |=> !hash_start)
		else $error("hash unit restarted back to back");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Cuckoo table check: every command beat is predicted against a shadow copy
// of the key and value stores, and each result beat is compared with the
// oldest pending prediction.
module testbench;

	localparam int TABLE_SIZE   = 8192;
	localparam int MAX_KICKS    = 16;
	localparam int RANDOM_BEATS = 1550;
	localparam int CLUSTER_KEYS = 48;
	localparam int SPARSE_KEYS  = 32;
	// Quiet cycles allowed before the run is called hung. The clearing sweep
	// after reset and a full displacement chain both stay well within it.
	localparam int STALL_LIMIT  = 3 * TABLE_SIZE;
	localparam int DRAIN_CYCLES = 400;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              busy;
	cht_pkg::cht_req_t req    = '0;
	logic              done;
	cht_pkg::cht_rsp_t rsp;

	// command beats still to send, and results still owed by the block
	cht_pkg::cht_req_t pending_beats[$];
	cht_pkg::cht_rsp_t owed_results[$];

	// shadow of the block's stores; a key is {word0, word1, word2, word3}
	logic [255:0] shadow_keys [TABLE_SIZE];
	logic [63:0]  shadow_vals [TABLE_SIZE];

	// key pools: dense clusters force displacement, sparse keys mostly do not
	logic [255:0] cluster_pool[$];
	logic [255:0] sparse_pool[$];

	bit beat_taken;
	int total_beats;
	int sent_beats;
	int errors;
	int quiet_cycles;

	cuckoo_hash_table #(
		.TABLE_SIZE(TABLE_SIZE),
		.MAX_KICKS (MAX_KICKS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// TABLE_SIZE is a power of two, so mod is the low 13 bits.
	function automatic logic [12:0] first_slot(input logic [255:0] k);
		return k[192 +: 13] ^ k[128 +: 13];
	endfunction

	function automatic logic [12:0] second_slot(input logic [255:0] k);
		return k[64 +: 13] ^ k[0 +: 13];
	endfunction

	// Random digest whose two candidate slots are a and b.
	function automatic logic [255:0] key_for_slots(input logic [12:0] a, input logic [12:0] b);
		logic [63:0] w0, w1, w2, w3;
		w0 = {$urandom, $urandom};
		w1 = {$urandom, $urandom};
		w2 = {$urandom, $urandom};
		w3 = {$urandom, $urandom};
		w1[12:0] = w0[12:0] ^ a;
		w3[12:0] = w2[12:0] ^ b;
		return {w0, w1, w2, w3};
	endfunction

	function automatic cht_pkg::cht_req_t make_beat(input logic [1:0] op,
			input logic [255:0] k, input logic [63:0] v);
		cht_pkg::cht_req_t r;
		r.operation = op;
		r.key_word0 = k[255:192];
		r.key_word1 = k[191:128];
		r.key_word2 = k[127:64];
		r.key_word3 = k[63:0];
		r.new_value = v;
		return r;
	endfunction

	function automatic logic [63:0] random_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 8)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Apply one command to the shadow stores and work out its result.
	task automatic cuckoo_predict(input cht_pkg::cht_req_t r, output cht_pkg::cht_rsp_t o);
		logic [255:0] k, held_key, evicted_key;
		logic [63:0]  held_val, evicted_val;
		logic [12:0]  h1, h2, idx, slot;
		int           kicks;
		bit           hit;
		k    = {r.key_word0, r.key_word1, r.key_word2, r.key_word3};
		h1   = first_slot(k);
		h2   = second_slot(k);
		o    = '0;
		slot = '0;
		hit  = 1'b0;
		case (r.operation)
		cht_pkg::OP_FIND_INSERT: begin
			if (shadow_keys[h1] == k) begin
				slot = h1;
			end else if (shadow_keys[h2] == k) begin
				slot = h2;
			end else if (shadow_vals[h1] == '0) begin
				shadow_keys[h1] = k;
				slot = h1;
			end else if (shadow_vals[h2] == '0) begin
				shadow_keys[h2] = k;
				slot = h2;
			end else begin
				// both full: kick residents out starting at h2, new key lands
				// there with an empty value
				idx      = h2;
				kicks    = 0;
				held_key = k;
				held_val = '0;
				do begin
					evicted_key      = shadow_keys[idx];
					evicted_val      = shadow_vals[idx];
					shadow_keys[idx] = held_key;
					shadow_vals[idx] = held_val;
					if (evicted_val != '0) begin
						idx = (idx == first_slot(evicted_key)) ? second_slot(evicted_key)
								: first_slot(evicted_key);
						held_key = evicted_key;
						held_val = evicted_val;
						kicks++;
					end
				end while (evicted_val != '0 && kicks != MAX_KICKS && idx != h2);
				if (evicted_val != '0) begin
					o.lost       = 1'b1;
					o.lost_value = evicted_val;
				end
				slot = h2;
			end
			if (shadow_vals[slot] != '0) begin
				o.found        = 1'b1;
				o.result_value = shadow_vals[slot];
			end else begin
				shadow_vals[slot] = r.new_value;
				o.result_value    = r.new_value;
			end
			o.slot_index = slot;
		end
		cht_pkg::OP_FIND, cht_pkg::OP_REMOVE: begin
			if (shadow_keys[h1] == k) begin
				slot = h1;
				hit  = 1'b1;
			end else if (shadow_keys[h2] == k) begin
				slot = h2;
				hit  = 1'b1;
			end
			if (hit) begin
				o.result_value = shadow_vals[slot];
				o.found        = (shadow_vals[slot] != '0);
				o.slot_index   = slot;
				if (r.operation == cht_pkg::OP_REMOVE) begin
					shadow_keys[slot] = '0;
					shadow_vals[slot] = '0;
				end
			end
		end
		default: begin
			// unused opcode: nothing changes, all-zero result
		end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	// Driver: a beat stays on req with start high until the edge takes it.
	// Idle gaps only open between beats, never while one is held.
	always @(negedge clk) begin
		bit          next_start;
		int unsigned idle_pct;
		if (arst_n) begin
			next_start = start;
			if (start && beat_taken) begin
				void'(pending_beats.pop_front());
				sent_beats++;
				next_start = 1'b0;
			end
			if (sent_beats < total_beats / 3)
				idle_pct = 23;
			else if (sent_beats < 2 * total_beats / 3)
				idle_pct = 69;
			else
				idle_pct = 0;
			if (!next_start && pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req        <= pending_beats[0];
				next_start  = 1'b1;
			end
			start <= next_start;
		end
	end

	// Monitor: results are checked first, since a result beat and a new
	// command beat never share an edge but the order keeps the queue honest.
	always @(posedge clk) begin
		cht_pkg::cht_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (owed_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got %p", $time, rsp);
				end else begin
					want = owed_results.pop_front();
					compare_field("found", want.found, rsp.found);
					compare_field("result_value", want.result_value, rsp.result_value);
					compare_field("slot_index", want.slot_index, rsp.slot_index);
					compare_field("lost", want.lost, rsp.lost);
					compare_field("lost_value", want.lost_value, rsp.lost_value);
				end
			end
			beat_taken = start && !busy;
			if (beat_taken) begin
				cuckoo_predict(req, want);
				owed_results.push_back(want);
			end
			quiet_cycles = (beat_taken || done) ? 0 : quiet_cycles + 1;
		end
	end

	// Watchdog: too long without any beat in either direction ends the run.
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [255:0] top_key, key_a, key_b, key_c;
		logic [12:0]  base;
		logic [1:0]   op;
		logic [255:0] k;
		int unsigned  pick;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end

		// two dense clusters: one at the bottom of the table (where the
		// all-zero digest lives) and one at the very top
		for (int i = 0; i < CLUSTER_KEYS; i++) begin
			base = $urandom_range(1) ? 13'd8168 : 13'd0;
			cluster_pool.push_back(key_for_slots(base + 13'($urandom_range(23)),
					base + 13'($urandom_range(23))));
		end
		for (int i = 0; i < SPARSE_KEYS; i++)
			sparse_pool.push_back(key_for_slots(13'($urandom), 13'($urandom)));

		// directed part
		top_key = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
		key_a   = key_for_slots(13'd5, 13'd9);
		key_b   = key_for_slots(13'd5, 13'd9);
		key_c   = key_for_slots(13'd5, 13'd9);
		// all-zero digest matches the cleared slot 0
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, '0, '0));
		// unused opcode with every other bit set
		pending_beats.push_back(make_beat(cht_pkg::OP_NONE, '1, '1));
		// remove of a key that is not there
		pending_beats.push_back(make_beat(cht_pkg::OP_REMOVE, top_key, '0));
		// top slot, both candidates equal, all-ones value
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, top_key, '1));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, top_key, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, top_key, 64'd5));
		// zero value stored: key stays but the slot counts as empty
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, '0, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, '0, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, '0, 64'h1234));
		// three keys on the same pair: h1, then h2, then a displacement that
		// comes back to h2 and drops an entry
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, key_a, 64'hA));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, key_b, 64'hB));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT, key_c, 64'hC));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, key_a, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, key_b, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, key_c, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_REMOVE, key_b, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, key_b, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_REMOVE, '0, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND, '0, '0));
		pending_beats.push_back(make_beat(cht_pkg::OP_FIND_INSERT,
				key_for_slots(13'd9, 13'd9), '1));
		pending_beats.push_back(make_beat(cht_pkg::OP_NONE, '0, '0));

		// random part: mostly pool keys, so inserts, hits and removes interleave
		// on the same entries; a few fresh digests as noise
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = cht_pkg::OP_FIND_INSERT;
			else if (pick < 75)
				op = cht_pkg::OP_FIND;
			else if (pick < 93)
				op = cht_pkg::OP_REMOVE;
			else
				op = cht_pkg::OP_NONE;
			pick = $urandom_range(99);
			if (pick < 78)
				k = cluster_pool[$urandom_range(CLUSTER_KEYS - 1)];
			else if (pick < 92)
				k = sparse_pool[$urandom_range(SPARSE_KEYS - 1)];
			else
				k = {$urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom};
			pending_beats.push_back(make_beat(op, k, random_value()));
		end
		total_beats = pending_beats.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		// stray late beats would still be caught here
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cht_pkg.sv
rtl/cht_slot_mod.sv
rtl/cuckoo_hash_table.sv
tb/testbench.sv
